@@ design/xvbr_pkg.sv @@
// Xing VBR header parser: shared types and constants.
// Used by the parser, the result queue and the top level; no dependencies.

package xvbr_pkg;

   // Seek table length of a standard Xing header
   localparam int unsigned TABLE_ENTRIES_DEF = 100;

   // Depth of the result queue (power of two, at least two)
   localparam int unsigned RSP_DEPTH = 4;

   // "Xing" as a big-endian word
   localparam logic [31:0] HDR_MAGIC = 32'h5869_6E67;

   // Bit positions in the flags word
   localparam int unsigned FLAG_FRAMES_BIT = 0;
   localparam int unsigned FLAG_BYTES_BIT  = 1;
   localparam int unsigned FLAG_TOC_BIT    = 2;
   localparam int unsigned FLAG_SCALE_BIT  = 3;

   // Result kinds
   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_region;
      logic       end_of_region;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [6:0]  table_index;
      logic [7:0]  table_value;
      logic        header_valid;
      logic [31:0] header_flags;
      logic [31:0] frame_count;
      logic [31:0] byte_count;
      logic [31:0] scale_value;
      logic        last_of_run;
   } rsp_type;

   // Up to two results written into the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

@@ design/xvbr_if.sv @@
// Valid/ready channel interfaces for the Xing VBR header parser.
// Self-contained; the field widths follow the byte and result formats.

interface xvbr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_region;
   logic       end_of_region;

   modport source (output valid, input ready, output data_byte, output start_of_region,
                   output end_of_region);
   modport sink   (input valid, output ready, input data_byte, input start_of_region,
                   input end_of_region);
endinterface

interface xvbr_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [6:0]  table_index;
   logic [7:0]  table_value;
   logic        header_valid;
   logic [31:0] header_flags;
   logic [31:0] frame_count;
   logic [31:0] byte_count;
   logic [31:0] scale_value;
   logic        last_of_run;

   modport source (output valid, input ready, output result_kind, output table_index,
                   output table_value, output header_valid, output header_flags,
                   output frame_count, output byte_count, output scale_value,
                   output last_of_run);
   modport sink   (input valid, output ready, input result_kind, input table_index,
                   input table_value, input header_valid, input header_flags,
                   input frame_count, input byte_count, input scale_value,
                   input last_of_run);
endinterface

@@ design/xing_vbr_header_parser.sv @@
// Xing VBR header parser, top level.
// Depends on xvbr_pkg, xvbr_if, xvbr_parse and xvbr_rsp_fifo.
//
// Usage:
//   req_chan carries the ancillary bytes of an MP3 frame, one per transfer,
//   with start_of_region on the first byte and end_of_region on the last.
//   rsp_chan carries results: one seek table entry per table byte, and one
//   summary (header_valid, flags, frame/byte counts, scale) when the header
//   completes or fails. A byte yields zero, one or two results; last_of_run
//   marks the last result of each byte.
//   A byte lands in the input register when it transfers; the parse logic
//   writes its results into the result queue once the queue has room, and
//   the queue offers them on rsp_chan.
//   Throughput: one byte per cycle while each byte yields at most one
//   result and rsp_chan.ready stays high; bytes with two results cannot keep
//   that up, as the single result port drains the four-entry queue.
//   Reset: synchronous; the parser goes idle and waits for a start mark,
//   the queue empties.
//   Stall: when rsp_chan.ready is low the queue fills; req_chan.ready drops
//   once a byte waits with fewer than two free entries; no result is lost.

module xing_vbr_header_parser #(
   parameter int unsigned TABLE_ENTRIES = xvbr_pkg::TABLE_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   xvbr_req_if.sink   req_chan,
   xvbr_rsp_if.source rsp_chan
);

   xvbr_pkg::req_type  req_item;
   xvbr_pkg::push_type push;
   xvbr_pkg::rsp_type  rsp_item;
   logic               room;

   // gather the request fields into one item
   assign req_item.data_byte       = req_chan.data_byte;
   assign req_item.start_of_region = req_chan.start_of_region;
   assign req_item.end_of_region   = req_chan.end_of_region;

   xvbr_parse #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_item  (req_item),
      .out_room (room),
      .push     (push)
   );

   xvbr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_rsp   (rsp_item)
   );

   // drive the head of the queue onto the result channel
   assign rsp_chan.result_kind  = rsp_item.result_kind;
   assign rsp_chan.table_index  = rsp_item.table_index;
   assign rsp_chan.table_value  = rsp_item.table_value;
   assign rsp_chan.header_valid = rsp_item.header_valid;
   assign rsp_chan.header_flags = rsp_item.header_flags;
   assign rsp_chan.frame_count  = rsp_item.frame_count;
   assign rsp_chan.byte_count   = rsp_item.byte_count;
   assign rsp_chan.scale_value  = rsp_item.scale_value;
   assign rsp_chan.last_of_run  = rsp_item.last_of_run;

endmodule

@@ design/xvbr_parse.sv @@
// Xing VBR header parser core: input register, parse state machine and result build.
// Depends on xvbr_pkg; feeds up to two results per byte into xvbr_rsp_fifo.

module xvbr_parse #(
   parameter int unsigned TABLE_ENTRIES = xvbr_pkg::TABLE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  xvbr_pkg::req_type  in_item,
   input  logic               out_room,
   output xvbr_pkg::push_type push
);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_MAGIC  = 3'd1;
   localparam logic [2:0] PH_FLAGS  = 3'd2;
   localparam logic [2:0] PH_FRAMES = 3'd3;
   localparam logic [2:0] PH_BYTES  = 3'd4;
   localparam logic [2:0] PH_TOC    = 3'd5;
   localparam logic [2:0] PH_SCALE  = 3'd6;
   localparam logic [2:0] PH_DONE   = 3'd7;

   localparam logic [7:0] TOC_LEN = 8'(TABLE_ENTRIES);

   // Next flagged section after the one just finished
   function automatic logic [2:0] next_phase(input logic [2:0] after, input logic [31:0] flags);
      logic [2:0] ph;
      if (after < PH_FRAMES && flags[xvbr_pkg::FLAG_FRAMES_BIT]) begin
         ph = PH_FRAMES;
      end else if (after < PH_BYTES && flags[xvbr_pkg::FLAG_BYTES_BIT]) begin
         ph = PH_BYTES;
      end else if (after < PH_TOC && flags[xvbr_pkg::FLAG_TOC_BIT]) begin
         ph = PH_TOC;
      end else if (after < PH_SCALE && flags[xvbr_pkg::FLAG_SCALE_BIT]) begin
         ph = PH_SCALE;
      end else begin
         ph = PH_DONE;
      end
      return ph;
   endfunction

   logic              item_valid_ff, item_valid_in;
   xvbr_pkg::req_type item_ff, item_in;
   logic              fire;

   logic [2:0]  phase_ff, phase_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] flags_ff, flags_in;
   logic [31:0] frames_ff, frames_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [31:0] scale_ff, scale_in;

   logic              entry_v, sum_v;
   xvbr_pkg::rsp_type entry_rsp, sum_rsp;

   assign fire          = item_valid_ff && out_room;
   assign in_ready      = !item_valid_ff || fire;
   assign item_valid_in = in_ready ? in_valid : item_valid_ff;
   assign item_in       = (in_ready && in_valid) ? in_item : item_ff;

   always_comb begin
      logic [2:0]  ph_c;
      logic [6:0]  cnt_c;
      logic [31:0] sh_c;
      logic [6:0]  cnt_inc;
      logic [31:0] sh_new;
      logic        adv;
      logic        failing;

      ph_c     = item_ff.start_of_region ? PH_MAGIC : phase_ff;
      cnt_c    = item_ff.start_of_region ? 7'd0 : cnt_ff;
      sh_c     = item_ff.start_of_region ? 32'd0 : shift_ff;
      cnt_inc  = cnt_c + 7'd1;
      sh_new   = {sh_c[23:0], item_ff.data_byte};
      adv      = 1'b0;
      failing  = 1'b0;

      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      flags_in  = flags_ff;
      frames_in = frames_ff;
      bytes_in  = bytes_ff;
      scale_in  = scale_ff;
      entry_v   = 1'b0;
      sum_v     = 1'b0;
      sum_rsp   = '0;
      sum_rsp.result_kind = xvbr_pkg::KIND_SUMMARY;
      sum_rsp.last_of_run = 1'b1;

      entry_rsp             = '0;
      entry_rsp.result_kind = xvbr_pkg::KIND_ENTRY;
      entry_rsp.table_index = cnt_c;
      entry_rsp.table_value = item_ff.data_byte;

      if (fire && ph_c != PH_IDLE && ph_c != PH_DONE) begin
         // a start mark clears everything before this byte is taken
         if (item_ff.start_of_region) begin
            flags_in  = '0;
            frames_in = '0;
            bytes_in  = '0;
            scale_in  = '0;
         end
         phase_in = ph_c;
         cnt_in   = cnt_inc;
         shift_in = sh_new;
         if (ph_c == PH_TOC) begin
            entry_v = 1'b1;
            if (cnt_inc == 7'd0 || {1'b0, cnt_inc} >= TOC_LEN) begin
               adv = 1'b1;
            end
         end else if (cnt_inc == 7'd4) begin
            unique case (ph_c)
               PH_MAGIC: begin
                  if (sh_new != xvbr_pkg::HDR_MAGIC) begin
                     failing = 1'b1;
                  end else begin
                     phase_in = PH_FLAGS;
                     cnt_in   = '0;
                     shift_in = '0;
                  end
               end
               PH_FLAGS: begin
                  flags_in = sh_new;
                  adv      = 1'b1;
               end
               PH_FRAMES: begin
                  frames_in = sh_new;
                  adv       = 1'b1;
               end
               PH_BYTES: begin
                  bytes_in = sh_new;
                  adv      = 1'b1;
               end
               default: begin
                  scale_in = sh_new;
                  adv      = 1'b1;
               end
            endcase
         end
         if (adv) begin
            phase_in = next_phase(ph_c, flags_in);
            cnt_in   = '0;
            shift_in = '0;
            if (phase_in == PH_DONE) begin
               sum_v                = 1'b1;
               sum_rsp.header_valid = 1'b1;
               sum_rsp.header_flags = flags_in;
               sum_rsp.frame_count  = frames_in;
               sum_rsp.byte_count   = bytes_in;
               sum_rsp.scale_value  = scale_in;
            end
         end
         // region ended before the last flagged section was complete
         if (item_ff.end_of_region && phase_in != PH_IDLE && phase_in != PH_DONE) begin
            failing = 1'b1;
         end
         if (failing) begin
            phase_in  = PH_IDLE;
            cnt_in    = '0;
            shift_in  = '0;
            flags_in  = '0;
            frames_in = '0;
            bytes_in  = '0;
            scale_in  = '0;
            sum_v     = 1'b1;
            sum_rsp   = '0;
            sum_rsp.result_kind = xvbr_pkg::KIND_SUMMARY;
            sum_rsp.last_of_run = 1'b1;
         end
      end

      entry_rsp.last_of_run = !sum_v;
      push.count  = {1'b0, entry_v} + {1'b0, sum_v};
      push.first  = entry_v ? entry_rsp : sum_rsp;
      push.second = sum_rsp;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_IDLE;
         cnt_ff        <= '0;
         shift_ff      <= '0;
         flags_ff      <= '0;
         frames_ff     <= '0;
         bytes_ff      <= '0;
         scale_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         shift_ff      <= shift_in;
         flags_ff      <= flags_in;
         frames_ff     <= frames_in;
         bytes_ff      <= bytes_in;
         scale_ff      <= scale_in;
      end
   end

endmodule

@@ design/xvbr_rsp_fifo.sv @@
// Result queue of the Xing VBR header parser: takes up to two results a cycle,
// hands out one per transfer. Depends on xvbr_pkg.

module xvbr_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  xvbr_pkg::push_type push,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output xvbr_pkg::rsp_type  out_rsp
);

   localparam int unsigned DEPTH = xvbr_pkg::RSP_DEPTH;
   localparam int unsigned PW    = $clog2(DEPTH);

   xvbr_pkg::rsp_type entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              pop;

   assign out_valid = count_ff != '0;
   assign out_rsp   = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // leave space for a byte that yields two results
   assign room      = count_ff <= (PW+1)'(DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + (PW+1)'(push.count) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PW'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
